>>> hdl/prht_pkg.sv
package prht_pkg;

	localparam int ENTRIES    = 16;
	localparam int COUNT_BITS = 8;
	localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int TOTAL_BITS = $clog2(ENTRIES + 1);
	localparam int ID_BITS    = 32;
	localparam int HANDLE_BITS = 32;
	localparam int OUT_COUNT_BITS = 8;

	typedef logic [COUNT_BITS-1:0] count_t;

	localparam count_t COUNT_MAX = '1;

	typedef enum logic [2:0] {
		FN_ADD      = 3'd0,
		FN_USE_LOCK = 3'd1,
		FN_UNLOCK   = 3'd2,
		FN_ACCESS   = 3'd3,
		FN_DESTROY  = 3'd4,
		FN_RESERVE  = 3'd5,
		FN_REMOVE   = 3'd6
	} func_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_REFUSED   = 3'd2,
		ST_FULL      = 3'd3,
		ST_UNDERFLOW = 3'd4
	} status_t;

	typedef struct packed {
		logic [ID_BITS-1:0]     id;
		logic [HANDLE_BITS-1:0] handle;
		count_t                 in_use;
		count_t                 reserve;
	} entry_t;

	localparam int ENTRY_BITS = $bits(entry_t);

	typedef struct packed {
		status_t                status;
		logic [HANDLE_BITS-1:0] handle;
		logic [OUT_COUNT_BITS-1:0] count;
	} result_t;

	typedef struct packed {
		logic wr;
		logic remove;
	} action_t;

	function automatic logic [OUT_COUNT_BITS-1:0] count_out(input count_t c);
		logic [COUNT_BITS+OUT_COUNT_BITS-1:0] w;
		w = {{OUT_COUNT_BITS{1'b0}}, c};
		return w[OUT_COUNT_BITS-1:0];
	endfunction

endpackage

>>> hdl/pin_reserve_handle_table_core.sv
// Handle table with pin and reserve counts. A request is taken when start is high and busy
// is low. Add, an unknown operation and any request on an empty table answer in the next
// cycle without raising busy. Every other operation scans the table one entry per cycle
// through the single read port of the entry RAM; a match goes on to the operate state
// before it answers, and a miss answers after the last entry. Remove then moves each later
// entry down one place, one per cycle, before it answers. Each request gives one result,
// shown for a single cycle with done high; the receiver cannot stall it and must take it
// in that cycle.
module pin_reserve_handle_table_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [2:0]                          func,
	input  logic signed [prht_pkg::ID_BITS-1:0] group_id,
	input  logic [prht_pkg::HANDLE_BITS-1:0]    new_handle,
	output logic                                done,
	output logic [2:0]                          status,
	output logic [prht_pkg::HANDLE_BITS-1:0]    handle_out,
	output logic [prht_pkg::OUT_COUNT_BITS-1:0] use_count_out
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_OP,
		S_SHIFT
	} state_t;

	state_t                              state_q;
	logic [prht_pkg::TOTAL_BITS-1:0]     total_q;
	logic [prht_pkg::IDX_BITS-1:0]       cmp_q;
	prht_pkg::func_t                     func_q;
	logic [prht_pkg::ID_BITS-1:0]        id_q;
	prht_pkg::entry_t                    ent_q;

	logic [prht_pkg::TOTAL_BITS-1:0]     nxt1;
	logic [prht_pkg::TOTAL_BITS-1:0]     nxt2;
	logic                                full;
	logic                                req;
	logic                                we;
	logic [prht_pkg::IDX_BITS-1:0]       waddr;
	logic [prht_pkg::IDX_BITS-1:0]       raddr;
	logic [prht_pkg::ENTRY_BITS-1:0]     wdata;
	logic [prht_pkg::ENTRY_BITS-1:0]     rdata;
	prht_pkg::entry_t                    rd_ent;
	prht_pkg::entry_t                    add_ent;
	prht_pkg::entry_t                    unit_ent;
	prht_pkg::entry_t                    unit_new;
	prht_pkg::result_t                   unit_res;
	prht_pkg::action_t                   unit_act;
	logic                                unit_match;

	assign busy   = (state_q != S_IDLE);
	assign req    = start && !busy;
	assign full   = (total_q >= prht_pkg::TOTAL_BITS'(prht_pkg::ENTRIES));
	assign nxt1   = prht_pkg::TOTAL_BITS'(cmp_q) + prht_pkg::TOTAL_BITS'(1);
	assign nxt2   = prht_pkg::TOTAL_BITS'(cmp_q) + prht_pkg::TOTAL_BITS'(2);
	assign rd_ent = prht_pkg::entry_t'(rdata);

	assign add_ent.id      = $unsigned(group_id);
	assign add_ent.handle  = new_handle;
	assign add_ent.in_use  = '0;
	assign add_ent.reserve = '0;

	assign unit_ent = (state_q == S_OP) ? ent_q : rd_ent;

	prht_unit u_unit (
		.func    (func_q),
		.id      (id_q),
		.ent     (unit_ent),
		.match   (unit_match),
		.ent_new (unit_new),
		.res     (unit_res),
		.act     (unit_act)
	);

	always_comb begin
		we    = 1'b0;
		waddr = cmp_q;
		wdata = unit_new;
		raddr = prht_pkg::IDX_BITS'(nxt1);
		unique case (state_q)
			S_IDLE: begin
				raddr = '0;
				waddr = prht_pkg::IDX_BITS'(total_q);
				wdata = add_ent;
				we    = req && (prht_pkg::func_t'(func) == prht_pkg::FN_ADD) && !full;
			end
			S_SCAN: begin
			end
			S_OP: begin
				we = unit_act.wr;
			end
			S_SHIFT: begin
				raddr = prht_pkg::IDX_BITS'(nxt2);
				wdata = rdata;
				we    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	prht_ram #(
		.WIDTH (prht_pkg::ENTRY_BITS),
		.DEPTH (prht_pkg::ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (req) begin
			func_q <= prht_pkg::func_t'(func);
			id_q   <= $unsigned(group_id);
		end
		if (state_q == S_SCAN && unit_match) begin
			ent_q <= rd_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			total_q       <= '0;
			cmp_q         <= '0;
			done          <= 1'b0;
			status        <= '0;
			handle_out    <= '0;
			use_count_out <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					cmp_q <= '0;
					if (req) begin
						if (prht_pkg::func_t'(func) == prht_pkg::FN_ADD) begin
							done          <= 1'b1;
							use_count_out <= '0;
							if (full) begin
								status     <= prht_pkg::ST_FULL;
								handle_out <= '0;
							end else begin
								status     <= prht_pkg::ST_OK;
								handle_out <= new_handle;
								total_q    <= total_q + 1'b1;
							end
						end else if (func == 3'(prht_pkg::FN_REMOVE + 1) || total_q == '0) begin
							done          <= 1'b1;
							status        <= prht_pkg::ST_NOT_FOUND;
							handle_out    <= '0;
							use_count_out <= '0;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (unit_match) begin
						state_q <= S_OP;
					end else if (nxt1 >= total_q) begin
						state_q       <= S_IDLE;
						done          <= 1'b1;
						status        <= prht_pkg::ST_NOT_FOUND;
						handle_out    <= '0;
						use_count_out <= '0;
					end else begin
						cmp_q <= prht_pkg::IDX_BITS'(nxt1);
					end
				end
				S_OP: begin
					status        <= unit_res.status;
					handle_out    <= unit_res.handle;
					use_count_out <= unit_res.count;
					if (unit_act.remove && nxt1 < total_q) begin
						state_q <= S_SHIFT;
					end else begin
						state_q <= S_IDLE;
						done    <= 1'b1;
						if (unit_act.remove) begin
							total_q <= total_q - 1'b1;
						end
					end
				end
				S_SHIFT: begin
					if (nxt2 < total_q) begin
						cmp_q <= prht_pkg::IDX_BITS'(nxt1);
					end else begin
						state_q <= S_IDLE;
						done    <= 1'b1;
						total_q <= total_q - 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hdl/prht_ram.sv
module prht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]               wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]               rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/prht_unit.sv
module prht_unit (
	input  prht_pkg::func_t                  func,
	input  logic [prht_pkg::ID_BITS-1:0]     id,
	input  prht_pkg::entry_t                 ent,
	output logic                             match,
	output prht_pkg::entry_t                 ent_new,
	output prht_pkg::result_t                res,
	output prht_pkg::action_t                act
);

	prht_pkg::count_t inc_use;
	prht_pkg::count_t dec_use;
	prht_pkg::count_t inc_rsv;

	assign match   = (ent.id == id);
	assign inc_use = (ent.in_use == prht_pkg::COUNT_MAX) ? ent.in_use : ent.in_use + 1'b1;
	assign dec_use = ent.in_use - 1'b1;
	assign inc_rsv = (ent.reserve == prht_pkg::COUNT_MAX) ? ent.reserve : ent.reserve + 1'b1;

	always_comb begin
		ent_new     = ent;
		res.status  = prht_pkg::ST_REFUSED;
		res.handle  = '0;
		res.count   = prht_pkg::count_out(ent.in_use);
		act         = '0;
		unique case (func)
			prht_pkg::FN_USE_LOCK: begin
				if (ent.reserve == '0) begin
					ent_new.in_use = inc_use;
					res.status     = prht_pkg::ST_OK;
					res.handle     = ent.handle;
					res.count      = prht_pkg::count_out(inc_use);
					act.wr         = 1'b1;
				end
			end
			prht_pkg::FN_UNLOCK: begin
				if (ent.in_use == '0) begin
					res.status = prht_pkg::ST_UNDERFLOW;
					res.count  = '0;
				end else begin
					ent_new.in_use = dec_use;
					res.status     = prht_pkg::ST_OK;
					res.count      = prht_pkg::count_out(dec_use);
					act.wr         = 1'b1;
				end
			end
			prht_pkg::FN_ACCESS: begin
				if (ent.reserve == '0) begin
					res.status = prht_pkg::ST_OK;
					res.handle = ent.handle;
				end
			end
			prht_pkg::FN_DESTROY: begin
				if (ent.in_use == '0) begin
					res.status = prht_pkg::ST_OK;
					res.handle = ent.handle;
				end
			end
			prht_pkg::FN_RESERVE: begin
				if (ent.in_use == '0) begin
					ent_new.reserve = inc_rsv;
					res.status      = prht_pkg::ST_OK;
					res.count       = '0;
					act.wr          = 1'b1;
				end
			end
			prht_pkg::FN_REMOVE: begin
				if (ent.in_use == '0) begin
					res.status = prht_pkg::ST_OK;
					res.handle = ent.handle;
					act.remove = 1'b1;
				end
			end
			default: begin
				res.status = prht_pkg::ST_NOT_FOUND;
				res.count  = '0;
			end
		endcase
	end

endmodule

>>> hdl/prht_checker.sv
module prht_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                done,
	input logic [2:0]                          status,
	input logic [prht_pkg::HANDLE_BITS-1:0]    handle_out,
	input logic [prht_pkg::OUT_COUNT_BITS-1:0] use_count_out
);

	// An accepted request either answers at once or keeps the block busy.
	a_req_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done || busy)
		else $error("accepted request neither answered nor started work");

	a_busy_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy ended without a result");

	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start || busy))
		else $error("result without a pending request");

	a_no_handle_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != 3'(prht_pkg::ST_OK) |-> handle_out == '0)
		else $error("handle given on a failed request");

	a_no_count_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == 3'(prht_pkg::ST_NOT_FOUND) || status == 3'(prht_pkg::ST_FULL) ||
		status == 3'(prht_pkg::ST_UNDERFLOW)) |-> use_count_out == '0)
		else $error("count given with a miss, full or underflow status");

endmodule

bind pin_reserve_handle_table_core prht_checker u_prht_checker (.*);
